### src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define APT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("apt assertion failed");

// checked at every edge, reset included
`define APT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("apt assertion failed");

`endif

### src/apt_pkg.sv
// types, constants and helpers for the affine point transform
// no dependencies
package apt_pkg;

  localparam int COORD_W = 16;
  localparam int FRAC_W  = COORD_W / 2;
  localparam int WIDE_W  = 48;
  localparam int SUM_W   = 66;
  localparam int TRIG_W  = 16;

  localparam logic [31:0] PI2_A1 = 32'd1686629713;
  localparam logic [31:0] PI2_A3 = 32'd693598668;
  localparam logic [31:0] PI2_A5 = 32'd85569306;
  localparam logic [31:0] PI2_A7 = 32'd5026995;
  localparam logic [31:0] PI2_A9 = 32'd172272;

  localparam logic [3*COORD_W-1:0] SCALE_RESET = 48'h0101_0101_0100;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

  typedef struct packed {
    coord_t local_z;
    coord_t local_y;
    coord_t local_x;
  } in_word_t;

  typedef struct packed {
    coord_t world_x;
    coord_t world_y;
    coord_t world_z;
    logic   saturated;
  } out_word_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sc_t;

  typedef struct packed {
    logic v;
    logic flag;
  } ctl_t;

  typedef enum logic [2:0] {
    CFG_SCALE      = 3'd0,
    CFG_ROTATE     = 3'd1,
    CFG_TRANSLATE  = 3'd2,
    CFG_PIVOT      = 3'd3,
    CFG_ORBIT      = 3'd4,
    CFG_PARENT     = 3'd5,
    CFG_PARENT_EN  = 3'd6
  } cfg_idx_t;

  localparam wide_t  WIDE_LIMIT = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam sum_t   SUM_HI     = SUM_W'(WIDE_LIMIT);
  localparam sum_t   SUM_LO     = -SUM_HI;
  localparam coord_t COORD_HI   = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_LO   = {1'b1, {(COORD_W-1){1'b0}}};

  function automatic logic over_wide(input sum_t v);
    return (v > SUM_HI) || (v < SUM_LO);
  endfunction

  function automatic wide_t clip_wide(input sum_t v);
    wide_t r;
    if (v > SUM_HI) begin
      r = WIDE_LIMIT;
    end else if (v < SUM_LO) begin
      r = -WIDE_LIMIT;
    end else begin
      r = v[WIDE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] horner_coef(input logic [1:0] k);
    logic [31:0] r;
    unique case (k)
      2'd0: r = PI2_A7;
      2'd1: r = PI2_A5;
      2'd2: r = PI2_A3;
      default: r = PI2_A1;
    endcase
    return r;
  endfunction

endpackage

### src/apt_trig.sv
// sine and cosine of the four configured angles, one shared multiplier
// depends on apt_pkg
module apt_trig #(
  parameter int ANGLE_WIDTH = 16,
  parameter int PHASE_BITS  = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [4*ANGLE_WIDTH-1:0]   angles,
  output logic                       busy,
  output apt_pkg::sc_t [3:0]         sc
);

  localparam int KEEP = (PHASE_BITS < ANGLE_WIDTH) ? PHASE_BITS : ANGLE_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_HORNER = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]  eval_r, eval_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [31:0] acc_r;
  logic [31:0] t2_r;
  apt_pkg::sc_t [3:0] sc_r;

  logic [ANGLE_WIDTH-1:0] angle;
  logic [31:0] ph;
  logic [31:0] t;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [33:0] prod_sh;
  logic [34:0] rnd_sum;
  logic [18:0] rnd;
  logic [14:0] mag;
  apt_pkg::trig_t val;

  always_comb begin
    angle   = angles[eval_r[2:1]*ANGLE_WIDTH +: ANGLE_WIDTH];
    ph      = {angle[ANGLE_WIDTH-1 -: KEEP], {(32-KEEP){1'b0}}}
              + (eval_r[0] ? 32'h4000_0000 : 32'h0);
    t       = ph[30] ? (32'h4000_0000 - {2'b00, ph[29:0]}) : {2'b00, ph[29:0]};
    unique case (state_r)
      ST_SQUARE: begin
        mul_a = t;
        mul_b = t;
      end
      ST_HORNER: begin
        mul_a = acc_r;
        mul_b = t2_r;
      end
      default: begin
        mul_a = acc_r;
        mul_b = t;
      end
    endcase
    prod    = mul_a * mul_b;
    prod_sh = prod[63:30];
    rnd_sum = {1'b0, prod_sh} + 35'h8000;
    rnd     = rnd_sum[34:16];
    mag     = (rnd > 19'd16384) ? 15'd16384 : rnd[14:0];
    val     = ph[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_comb begin
    state_nxt = state_r;
    eval_nxt  = eval_r;
    hcnt_nxt  = hcnt_r;
    unique case (state_r)
      ST_IDLE: begin
        state_nxt = ST_IDLE;
      end
      ST_SQUARE: begin
        state_nxt = ST_HORNER;
        hcnt_nxt  = 2'd0;
      end
      ST_HORNER: begin
        hcnt_nxt = hcnt_r + 2'd1;
        if (hcnt_r == 2'd3) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (eval_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SQUARE;
          eval_nxt  = eval_r + 3'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (start) begin
      state_nxt = ST_SQUARE;
      eval_nxt  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SQUARE;
      eval_r  <= 3'd0;
      hcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      eval_r  <= eval_nxt;
      hcnt_r  <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_SQUARE: begin
        t2_r  <= prod_sh[31:0];
        acc_r <= apt_pkg::PI2_A9;
      end
      ST_HORNER: begin
        acc_r <= apt_pkg::horner_coef(hcnt_r) - prod_sh[31:0];
      end
      ST_FINISH: begin
        if (eval_r[0]) begin
          sc_r[eval_r[2:1]].c <= val;
        end else begin
          sc_r[eval_r[2:1]].s <= val;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign sc   = sc_r;

endmodule

### src/apt_rot.sv
// two-stage plane rotation: products, then round and clip
// depends on apt_pkg
module apt_rot (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  apt_pkg::ctl_t     in_ctl,
  input  apt_pkg::wide_t    in_a,
  input  apt_pkg::wide_t    in_b,
  input  apt_pkg::wide_t    in_o,
  input  apt_pkg::sc_t      sc,
  output apt_pkg::ctl_t     out_ctl,
  output apt_pkg::wide_t    out_a,
  output apt_pkg::wide_t    out_b,
  output apt_pkg::wide_t    out_o
);

  localparam int PW = apt_pkg::WIDE_W + apt_pkg::TRIG_W;
  localparam apt_pkg::sum_t HALF = apt_pkg::sum_t'(1) <<< 13;

  apt_pkg::ctl_t ctl1_r, ctl2_r;
  logic signed [PW-1:0] ac_r, bs_r, as_r, bc_r;
  apt_pkg::wide_t o1_r, a2_r, b2_r, o2_r;
  apt_pkg::sum_t na, nb;

  always_comb begin
    na = (apt_pkg::sum_t'(ac_r) - apt_pkg::sum_t'(bs_r) + HALF) >>> 14;
    nb = (apt_pkg::sum_t'(as_r) + apt_pkg::sum_t'(bc_r) + HALF) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl1_r <= in_ctl;
      ctl2_r <= '{v: ctl1_r.v,
                  flag: ctl1_r.flag | apt_pkg::over_wide(na) | apt_pkg::over_wide(nb)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ac_r <= in_a * sc.c;
      bs_r <= in_b * sc.s;
      as_r <= in_a * sc.s;
      bc_r <= in_b * sc.c;
      o1_r <= in_o;
      a2_r <= apt_pkg::clip_wide(na);
      b2_r <= apt_pkg::clip_wide(nb);
      o2_r <= o1_r;
    end
  end

  assign out_ctl = ctl2_r;
  assign out_a   = a2_r;
  assign out_b   = b2_r;
  assign out_o   = o2_r;

endmodule

### src/affine_point_transform_unit.sv
// throughput one word per cycle while in_ready is high
// the pipeline stalls as a whole only while the output word waits to be taken
// after reset and after every config write the trig unit works out the
// four sine/cosine pairs (one multiply per cycle), with in_ready low meanwhile
// reset (synchronous, rst_n low) clears the pipeline and loads the register defaults
module affine_point_transform_unit #(
  parameter int ANGLE_WIDTH      = 16,
  parameter int SINE_TABLE_DEPTH = 1024,
  localparam int ROT_FULL = 3 * ANGLE_WIDTH,
  localparam int ROT_W    = (ROT_FULL > 64) ? 64 : ROT_FULL,
  localparam int CFG_W    = (ROT_W > 3*apt_pkg::COORD_W) ? ROT_W : 3*apt_pkg::COORD_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  apt_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output apt_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int CW = apt_pkg::COORD_W;
  localparam int PHASE_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam apt_pkg::sum_t SCALE_HALF = apt_pkg::sum_t'(1) <<< (apt_pkg::FRAC_W - 1);

  logic [3*CW-1:0]        scale_r, translate_r, pivot_r, parent_r;
  logic [ROT_W-1:0]       rotate_r;
  logic [ANGLE_WIDTH-1:0] orbit_r;
  logic                   parent_en_r;

  logic [ROT_FULL-1:0] rot_ext;
  logic                busy;
  logic                en;
  apt_pkg::sc_t [3:0]  sc;

  apt_pkg::coord_t loc [3];
  apt_pkg::coord_t scl [3];
  apt_pkg::coord_t trn [3];
  apt_pkg::coord_t piv [3];
  apt_pkg::coord_t par [3];

  apt_pkg::ctl_t ctl1_r, ctl2_r, ctl3, ctl4, ctl5, ctl6_r, ctl7;
  logic signed [2*CW-1:0] prod1_r [3];
  apt_pkg::wide_t p2_r [3];
  apt_pkg::wide_t p3 [3];
  apt_pkg::wide_t p4 [3];
  apt_pkg::wide_t p5 [3];
  apt_pkg::wide_t p6_r [3];
  apt_pkg::wide_t p7 [3];

  apt_pkg::sum_t    r2 [3];
  apt_pkg::sum_t    t6 [3];
  apt_pkg::sum_t    fs [3];
  apt_pkg::coord_t  sat [3];
  logic [2:0]       over2, over6, hit;

  logic               out_valid_r;
  apt_pkg::out_word_t out_data_r;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= apt_pkg::SCALE_RESET;
      rotate_r    <= '0;
      translate_r <= '0;
      pivot_r     <= '0;
      orbit_r     <= '0;
      parent_r    <= '0;
      parent_en_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (apt_pkg::cfg_idx_t'(cfg_index))
        apt_pkg::CFG_SCALE:     scale_r     <= cfg_data[3*CW-1:0];
        apt_pkg::CFG_ROTATE:    rotate_r    <= cfg_data[ROT_W-1:0];
        apt_pkg::CFG_TRANSLATE: translate_r <= cfg_data[3*CW-1:0];
        apt_pkg::CFG_PIVOT:     pivot_r     <= cfg_data[3*CW-1:0];
        apt_pkg::CFG_ORBIT:     orbit_r     <= cfg_data[ANGLE_WIDTH-1:0];
        apt_pkg::CFG_PARENT:    parent_r    <= cfg_data[3*CW-1:0];
        apt_pkg::CFG_PARENT_EN: parent_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign rot_ext = ROT_FULL'(rotate_r);

  apt_trig #(
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .PHASE_BITS  (PHASE_BITS)
  ) u_trig (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cfg_valid),
    .angles ({orbit_r, rot_ext[2*ANGLE_WIDTH +: ANGLE_WIDTH],
              rot_ext[ANGLE_WIDTH +: ANGLE_WIDTH], rot_ext[0 +: ANGLE_WIDTH]}),
    .busy   (busy),
    .sc     (sc)
  );

  always_comb begin
    loc[0] = in_data.local_x;
    loc[1] = in_data.local_y;
    loc[2] = in_data.local_z;
    for (int k = 0; k < 3; k++) begin
      scl[k] = scale_r[k*CW +: CW];
      trn[k] = translate_r[k*CW +: CW];
      piv[k] = pivot_r[k*CW +: CW];
      par[k] = parent_r[k*CW +: CW];
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en && !busy && !cfg_valid;

  // scale
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r2[k]    = (apt_pkg::sum_t'(prod1_r[k]) + SCALE_HALF) >>> apt_pkg::FRAC_W;
      over2[k] = apt_pkg::over_wide(r2[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else if (en) begin
      ctl1_r <= '{v: in_valid && in_ready, flag: 1'b0};
      ctl2_r <= '{v: ctl1_r.v, flag: |over2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod1_r[k] <= loc[k] * scl[k];
        p2_r[k]    <= apt_pkg::clip_wide(r2[k]);
      end
    end
  end

  // rotate about x, then y, then z
  apt_rot u_rot_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_ctl(ctl2_r),
    .in_a(p2_r[1]), .in_b(p2_r[2]), .in_o(p2_r[0]), .sc(sc[0]),
    .out_ctl(ctl3), .out_a(p3[1]), .out_b(p3[2]), .out_o(p3[0])
  );

  apt_rot u_rot_y (
    .clk(clk), .rst_n(rst_n), .en(en), .in_ctl(ctl3),
    .in_a(p3[2]), .in_b(p3[0]), .in_o(p3[1]), .sc(sc[1]),
    .out_ctl(ctl4), .out_a(p4[2]), .out_b(p4[0]), .out_o(p4[1])
  );

  apt_rot u_rot_z (
    .clk(clk), .rst_n(rst_n), .en(en), .in_ctl(ctl4),
    .in_a(p4[0]), .in_b(p4[1]), .in_o(p4[2]), .sc(sc[2]),
    .out_ctl(ctl5), .out_a(p5[0]), .out_b(p5[1]), .out_o(p5[2])
  );

  // translate and move to pivot frame
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t6[k]    = apt_pkg::sum_t'(p5[k]) + apt_pkg::sum_t'(trn[k])
                 - apt_pkg::sum_t'(piv[k]);
      over6[k] = apt_pkg::over_wide(t6[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl6_r <= '0;
    end else if (en) begin
      ctl6_r <= '{v: ctl5.v, flag: ctl5.flag | (|over6)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p6_r[k] <= apt_pkg::clip_wide(t6[k]);
      end
    end
  end

  // orbit about z
  apt_rot u_rot_orbit (
    .clk(clk), .rst_n(rst_n), .en(en), .in_ctl(ctl6_r),
    .in_a(p6_r[0]), .in_b(p6_r[1]), .in_o(p6_r[2]), .sc(sc[3]),
    .out_ctl(ctl7), .out_a(p7[0]), .out_b(p7[1]), .out_o(p7[2])
  );

  // back from pivot frame, parent offset, saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fs[k] = apt_pkg::sum_t'(p7[k]) + apt_pkg::sum_t'(piv[k])
              + (parent_en_r ? apt_pkg::sum_t'(par[k]) : apt_pkg::sum_t'(0));
      if (fs[k] > apt_pkg::sum_t'(apt_pkg::COORD_HI)) begin
        sat[k] = apt_pkg::COORD_HI;
        hit[k] = 1'b1;
      end else if (fs[k] < apt_pkg::sum_t'(apt_pkg::COORD_LO)) begin
        sat[k] = apt_pkg::COORD_LO;
        hit[k] = 1'b1;
      end else begin
        sat[k] = fs[k][CW-1:0];
        hit[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl7.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= '{world_x: sat[0], world_y: sat[1], world_z: sat[2],
                      saturated: ctl7.flag | (|hit)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/apt_checker.sv
// port-level checks on the affine point transform, bound to the top level
// depends on apt_pkg and assert_macros.svh
`include "assert_macros.svh"

module apt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input apt_pkg::out_word_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  `APT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `APT_ASSERT(a_stall_blocks_in, out_valid && !out_ready |-> !in_ready)
  `APT_ASSERT(a_cfg_busy, cfg_valid && cfg_ready |=> !in_ready)
  `APT_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid)
  `APT_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> !in_ready)

endmodule

bind affine_point_transform_unit apt_checker u_apt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
